@@ hw/rtl/hps_pkg.sv @@
// Package for the linear-probing hash set: shared widths, step and jump codes,
// control/status structs and the microcode ROM.
// Depends on nothing; every other file of the block uses it.
package hps_pkg;

  localparam int unsigned KEY_W  = 31;
  localparam int unsigned SLOT_W = 6;
  // Home slot is found one 4-bit key digit per step, most significant first
  localparam int unsigned DIG_W  = 4;
  localparam int unsigned N_DIG  = 8;
  localparam int unsigned SH_W   = DIG_W * N_DIG;
  localparam int unsigned DCNT_W = 3;
  localparam int unsigned N_SUB  = (1 << DIG_W) - 1;

  // Microprogram steps
  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_READ,
    S_TEST,
    S_MATCH,
    S_ADV,
    S_FULL,
    S_EMPTY,
    S_HIT,
    S_RESP
  } step_e;

  // Jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_REQ,
    C_MOD_MORE,
    C_EMPTY,
    C_MATCH,
    C_MORE,
    C_OUT_BUSY
  } cond_e;

  // Datapath actions of one step
  typedef struct packed {
    logic accept;
    logic mod_step;
    logic adv;
    logic res_full;
    logic res_empty;
    logic res_hit;
    logic out_load;
  } ctrl_t;

  // Datapath flags tested by jumps
  typedef struct packed {
    logic req_valid;
    logic mod_more;
    logic empty;
    logic match;
    logic more;
    logic out_busy;
  } stat_t;

  // One control word: jump condition, taken target, fall-through target, actions
  typedef struct packed {
    cond_e cond;
    step_e tgt;
    step_e nxt;
    ctrl_t act;
  } uword_t;

  localparam ctrl_t NO_ACT = '0;

  // Microcode ROM
  function automatic uword_t ucode(step_e s);
    uword_t w;
    w.cond = C_ALWAYS;
    w.tgt  = S_IDLE;
    w.nxt  = S_IDLE;
    w.act  = NO_ACT;
    unique case (s)
      S_IDLE: begin
        w.cond = C_NO_REQ;  w.tgt = S_IDLE;  w.nxt = S_MOD;
        w.act.accept = 1'b1;
      end
      S_MOD: begin
        w.cond = C_MOD_MORE; w.tgt = S_MOD;  w.nxt = S_READ;
        w.act.mod_step = 1'b1;
      end
      S_READ: begin
        w.cond = C_ALWAYS;  w.tgt = S_TEST;  w.nxt = S_TEST;
      end
      S_TEST: begin
        w.cond = C_EMPTY;   w.tgt = S_EMPTY; w.nxt = S_MATCH;
      end
      S_MATCH: begin
        w.cond = C_MATCH;   w.tgt = S_HIT;   w.nxt = S_ADV;
      end
      S_ADV: begin
        w.cond = C_MORE;    w.tgt = S_READ;  w.nxt = S_FULL;
        w.act.adv = 1'b1;
      end
      S_FULL: begin
        w.cond = C_ALWAYS;  w.tgt = S_RESP;  w.nxt = S_RESP;
        w.act.res_full = 1'b1;
      end
      S_EMPTY: begin
        w.cond = C_ALWAYS;  w.tgt = S_RESP;  w.nxt = S_RESP;
        w.act.res_empty = 1'b1;
      end
      S_HIT: begin
        w.cond = C_ALWAYS;  w.tgt = S_RESP;  w.nxt = S_RESP;
        w.act.res_hit = 1'b1;
      end
      S_RESP: begin
        w.cond = C_OUT_BUSY; w.tgt = S_RESP; w.nxt = S_IDLE;
        w.act.out_load = 1'b1;
      end
      default: begin
        w.cond = C_ALWAYS;  w.tgt = S_IDLE;  w.nxt = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/hps_if.sv @@
// Valid/ready channel interfaces for request and result items of the hash set.
// Depends on hps_pkg for the field widths.
interface hps_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [hps_pkg::KEY_W-1:0]   key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface hps_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic                        stored;
  logic                        full_res;
  logic [hps_pkg::SLOT_W-1:0]  slot;

  modport source (output valid, output hit, output stored, output full_res, output slot,
                  input ready);
  modport sink   (input valid, input hit, input stored, input full_res, input slot,
                  output ready);
endinterface

@@ hw/rtl/linear_probe_hash_set_unit.sv @@
// Linear-probing hash set of 31-bit keys in TABLE_SIZE slots, one valid bit
// per slot.
// Channels: req_i (req_type 0 = insert, 1 = look up; key) and rsp_o (hit,
// stored, full_res, slot), both valid/ready; an item moves when both are high.
// One item is in work at a time. After it is taken, a microcoded sequencer
// folds the key into its home slot (4 key bits per cycle), then probes the
// slots in turn, each through key memory read, empty test, key compare and
// advance. The block takes no new request before the last result is loaded;
// the next request can be taken in the cycle after the result is loaded.
// Reset clears all valid bits at once, so the table is empty with no clearing
// pass. A result waits in the output register while rsp_o.ready is low; the
// sequencer holds in its response step until that register is free, and
// req_i.ready stays low meanwhile except when the sequencer is idle.
// Depends on hps_pkg, hps_if, hps_useq and hps_dpath.
module linear_probe_hash_set_unit #(
  parameter int unsigned TABLE_SIZE = 11
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  hps_req_if.sink  req_i,
  hps_rsp_if.source rsp_o
);

  hps_pkg::ctrl_t ctrl;
  hps_pkg::stat_t stat;
  hps_pkg::step_e step;

  hps_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .step_o (step)
  );

  hps_dpath #(
    .TableSize (TABLE_SIZE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (req_i.valid),
    .req_type_i  (req_i.req_type),
    .key_i       (req_i.key),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .hit_o       (rsp_o.hit),
    .stored_o    (rsp_o.stored),
    .full_res_o  (rsp_o.full_res),
    .slot_o      (rsp_o.slot)
  );

  assign req_i.ready = ctrl.accept;

`ifndef SYNTHESIS
  // An accepted item starts the key fold in the next cycle
  a_accept_to_mod : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> step == hps_pkg::S_MOD)
    else $error("accepted item did not start the home slot fold");

  // A new result appears only after the response step
  a_rsp_from_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(step == hps_pkg::S_RESP))
    else $error("result loaded outside the response step");

  // At most one outcome flag per result
  a_one_outcome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> $countones({rsp_o.hit, rsp_o.stored, rsp_o.full_res}) <= 1)
    else $error("more than one outcome flag set");

  // Slot is zero unless the key was found or stored
  a_slot_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.hit && !rsp_o.stored |-> rsp_o.slot == '0)
    else $error("nonzero slot on miss or full");
`endif

endmodule

@@ hw/rtl/hps_useq.sv @@
// Microcode sequencer: step register, control word fetch from the ROM in
// hps_pkg and conditional jump selection. Depends on hps_pkg.
module hps_useq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hps_pkg::stat_t        stat_i,
  output hps_pkg::ctrl_t        ctrl_o,
  output hps_pkg::step_e        step_o
);

  hps_pkg::step_e  step_q, step_d;
  hps_pkg::uword_t word;
  logic            taken;

  // Hold the current step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= hps_pkg::S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Fetch the control word and pick the next step
  always_comb begin
    word = hps_pkg::ucode(step_q);
    unique case (word.cond)
      hps_pkg::C_ALWAYS:   taken = 1'b1;
      hps_pkg::C_NO_REQ:   taken = !stat_i.req_valid;
      hps_pkg::C_MOD_MORE: taken = stat_i.mod_more;
      hps_pkg::C_EMPTY:    taken = stat_i.empty;
      hps_pkg::C_MATCH:    taken = stat_i.match;
      hps_pkg::C_MORE:     taken = stat_i.more;
      hps_pkg::C_OUT_BUSY: taken = stat_i.out_busy;
      default:             taken = 1'b1;
    endcase
    step_d = taken ? word.tgt : word.nxt;
  end

  assign ctrl_o = word.act;
  assign step_o = step_q;

endmodule

@@ hw/rtl/hps_dpath.sv @@
// Datapath of the hash set: key and digit registers, home-slot remainder unit,
// slot index and probe counters, key memory, valid bits, result and output
// registers. Driven by the control word from hps_useq. Depends on hps_pkg.
module hps_dpath #(
  parameter int unsigned TableSize = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hps_pkg::ctrl_t                ctrl_i,
  output hps_pkg::stat_t                stat_o,
  input  logic                          in_valid_i,
  input  logic                          req_type_i,
  input  logic [hps_pkg::KEY_W-1:0]     key_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          hit_o,
  output logic                          stored_o,
  output logic                          full_res_o,
  output logic [hps_pkg::SLOT_W-1:0]    slot_o
);

  localparam int unsigned IW = (TableSize > 1) ? $clog2(TableSize) : 1;
  localparam int unsigned VW = IW + hps_pkg::DIG_W;
  localparam logic [IW-1:0] LAST = IW'(TableSize - 1);

  logic                          ld;
  logic                          out_busy;
  logic                          we;
  logic                          lookup_q;
  logic [hps_pkg::KEY_W-1:0]     key_q;
  logic [hps_pkg::SH_W-1:0]      key_sh_q;
  logic [hps_pkg::DCNT_W-1:0]    dcnt_q;
  logic [IW-1:0]                 idx_q;
  logic [IW-1:0]                 pcnt_q;
  logic [TableSize-1:0]          valid_q;
  logic [hps_pkg::KEY_W-1:0]     key_mem [TableSize];
  logic [hps_pkg::KEY_W-1:0]     rd_q;
  logic [VW-1:0]                 mod_v;
  logic [VW-1:0]                 mod_r;
  logic                          res_hit_q, res_stored_q, res_full_q;
  logic [IW-1:0]                 res_slot_q;
  logic                          out_valid_q;
  logic                          out_hit_q, out_stored_q, out_full_q;
  logic [hps_pkg::SLOT_W-1:0]    out_slot_q;

  assign ld       = ctrl_i.accept & in_valid_i;
  assign out_busy = out_valid_q & !out_ready_i;
  assign we       = ctrl_i.res_empty & !lookup_q;

  // Fold in one key digit: r = (16*r + digit) mod TableSize, r < TableSize
  always_comb begin
    mod_v = {idx_q, key_sh_q[hps_pkg::SH_W-1 -: hps_pkg::DIG_W]};
    mod_r = mod_v;
    for (int k = 1; k <= int'(hps_pkg::N_SUB); k++) begin
      if (mod_v >= VW'(k * TableSize)) begin
        mod_r = mod_v - VW'(k * TableSize);
      end
    end
  end

  // Load the item, then walk digits and probe slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lookup_q <= 1'b0;
      key_q    <= '0;
      key_sh_q <= '0;
      dcnt_q   <= '0;
      idx_q    <= '0;
      pcnt_q   <= '0;
    end else if (ld) begin
      lookup_q <= req_type_i;
      key_q    <= key_i;
      key_sh_q <= {1'b0, key_i};
      dcnt_q   <= '0;
      idx_q    <= '0;
      pcnt_q   <= '0;
    end else if (ctrl_i.mod_step) begin
      key_sh_q <= key_sh_q << hps_pkg::DIG_W;
      dcnt_q   <= dcnt_q + 1'b1;
      idx_q    <= mod_r[IW-1:0];
    end else if (ctrl_i.adv) begin
      idx_q  <= (idx_q == LAST) ? '0 : idx_q + 1'b1;
      pcnt_q <= pcnt_q + 1'b1;
    end
  end

  // Mark a slot occupied when an insert stores into it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  // Key memory: one write port, registered read at the probe index
  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[idx_q] <= key_q;
    end
    rd_q <= key_mem[idx_q];
  end

  // Record the outcome of the probe
  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_full) begin
      res_hit_q    <= 1'b0;
      res_stored_q <= 1'b0;
      res_full_q   <= !lookup_q;
      res_slot_q   <= '0;
    end else if (ctrl_i.res_empty) begin
      res_hit_q    <= 1'b0;
      res_stored_q <= !lookup_q;
      res_full_q   <= 1'b0;
      res_slot_q   <= lookup_q ? '0 : idx_q;
    end else if (ctrl_i.res_hit) begin
      res_hit_q    <= 1'b1;
      res_stored_q <= 1'b0;
      res_full_q   <= 1'b0;
      res_slot_q   <= idx_q;
    end
  end

  // Output register: load when free or being drained, drop on take
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load && !out_busy) begin
      out_hit_q    <= res_hit_q;
      out_stored_q <= res_stored_q;
      out_full_q   <= res_full_q;
      out_slot_q   <= hps_pkg::SLOT_W'(res_slot_q);
    end
  end

  // Flags for the sequencer
  always_comb begin
    stat_o.req_valid = in_valid_i;
    stat_o.mod_more  = dcnt_q != hps_pkg::DCNT_W'(hps_pkg::N_DIG - 1);
    stat_o.empty     = !valid_q[idx_q];
    stat_o.match     = rd_q == key_q;
    stat_o.more      = pcnt_q != LAST;
    stat_o.out_busy  = out_busy;
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign stored_o    = out_stored_q;
  assign full_res_o  = out_full_q;
  assign slot_o      = out_slot_q;

endmodule

@@ tb/linear_probe_hash_set_unit_tb.sv @@
// Testbench for linear_probe_hash_set_unit: drives insert and lookup items
// and checks every result against a table model kept in the bench.
// Depends on hps_pkg, hps_if and the block's RTL.
`timescale 1ns / 100ps

module linear_probe_hash_set_unit_tb;

  localparam int unsigned KEY_W        = hps_pkg::KEY_W;
  localparam int unsigned SLOT_W       = hps_pkg::SLOT_W;
  localparam int unsigned TABLE_SIZE   = 11;
  localparam int unsigned MAX_GAP      = 14;
  localparam int unsigned CYCLE_LIMIT  = 800_000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned MAX_REPORTS  = 10;

  // Request codes on req_type
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic              hit;
    logic              stored;
    logic              full_res;
    logic [SLOT_W-1:0] slot;
  } probe_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hps_req_if req_ch ();
  hps_rsp_if rsp_ch ();

  linear_probe_hash_set_unit #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  always #4 clk_i = ~clk_i;

  // Bench copy of the table
  logic [KEY_W-1:0] tbl_keys  [TABLE_SIZE];
  bit               tbl_valid [TABLE_SIZE];

  probe_res_t pending_q [$];
  int unsigned fail_cnt;
  bit          send_idle;
  bit          recv_idle;
  int unsigned rsp_hold_len;

  // Probe the table as the block does and apply an insert
  function automatic probe_res_t probe_table(input logic req_type,
                                             input logic [KEY_W-1:0] key);
    probe_res_t  res;
    int unsigned idx;
    bit          done;
    res  = '0;
    idx  = key % TABLE_SIZE;
    done = 1'b0;
    for (int n = 0; n < TABLE_SIZE && !done; n++) begin
      if (!tbl_valid[idx]) begin
        if (req_type == REQ_INSERT) begin
          tbl_keys[idx]  = key;
          tbl_valid[idx] = 1'b1;
          res.stored     = 1'b1;
          res.slot       = SLOT_W'(idx);
        end
        done = 1'b1;
      end else if (tbl_keys[idx] == key) begin
        res.hit  = 1'b1;
        res.slot = SLOT_W'(idx);
        done     = 1'b1;
      end else begin
        idx = (idx + 1 == TABLE_SIZE) ? 0 : idx + 1;
      end
    end
    if (!done && req_type == REQ_INSERT) res.full_res = 1'b1;
    return res;
  endfunction

  function automatic int unsigned draw_gap(input bit enabled);
    return enabled ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  // Mix stored keys, keys sharing a home slot, small keys and wide random keys
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned      sel;
    int unsigned      s;
    logic [KEY_W-1:0] k;
    sel = $urandom_range(0, 9);
    s   = $urandom_range(0, TABLE_SIZE - 1);
    k   = KEY_W'($urandom());
    if (sel < 4 && tbl_valid[s]) begin
      k = tbl_keys[s];
    end else if (sel < 6 && tbl_valid[s]) begin
      k = tbl_keys[s] + KEY_W'(TABLE_SIZE * $urandom_range(1, 5));
    end else if (sel < 8) begin
      k = KEY_W'($urandom_range(0, 63));
    end
    return k;
  endfunction

  // Offer one item and record its expected result once it is taken
  task automatic send_req(input logic req_type, input logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = draw_gap(send_idle);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= req_type;
    req_ch.key      <= key;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    pending_q.push_back(probe_table(req_type, key));
  endtask

  // Drop valid after the last item of a burst
  task automatic release_req();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_for_drain();
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      send_req($urandom_range(0, 1) ? REQ_LOOKUP : REQ_INSERT, pick_key());
    end
  endtask

  // Collision chains, wraparound, duplicates, hits, misses and a full table
  task automatic test_directed_cases();
    send_req(REQ_LOOKUP, 31'd0);
    send_req(REQ_INSERT, 31'd0);
    send_req(REQ_INSERT, 31'd0);
    send_req(REQ_LOOKUP, 31'd0);
    send_req(REQ_INSERT, 31'd11);
    send_req(REQ_INSERT, 31'd22);
    send_req(REQ_LOOKUP, 31'd33);
    send_req(REQ_LOOKUP, 31'd22);
    send_req(REQ_INSERT, 31'd10);
    send_req(REQ_INSERT, 31'd21);
    send_req(REQ_LOOKUP, 31'd32);
    send_req(REQ_INSERT, 31'h7FFF_FFFF);
    send_req(REQ_LOOKUP, 31'h7FFF_FFFF);
    for (int k = 5; k <= 9; k++) send_req(REQ_INSERT, KEY_W'(k));
    send_req(REQ_INSERT, 31'h2AAA_AAAA);
    send_req(REQ_LOOKUP, 31'h5555_5555);
    send_req(REQ_INSERT, 31'd9);
    send_req(REQ_LOOKUP, 31'd21);
    send_req(REQ_INSERT, 31'd32);
  endtask

  task automatic test_random_traffic();
    send_random(1400);
  endtask

  // Run both sides without gaps
  task automatic test_back_to_back();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_random(200);
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Hold the result side for a long stretch while items keep coming
  task automatic test_output_backpressure();
    send_idle    = 1'b0;
    rsp_hold_len = LONG_HOLD;
    send_random(40);
    send_idle    = 1'b1;
  endtask

  // Pause the request side until every result is back
  task automatic test_drain_pause();
    send_random(30);
    release_req();
    wait_for_drain();
    send_random(30);
  endtask

  // Result side: stall per item, or hold long when asked
  initial begin : rsp_accept
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rsp_hold_len > 0) begin
        stall        = rsp_hold_len;
        rsp_hold_len = 0;
      end else begin
        stall = draw_gap(recv_idle);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_ch.valid) @(posedge clk_i);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    probe_res_t want;
    if (rst_ni === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: result with no pending request: hit %b stored %b full %b slot %0d",
                   $realtime, rsp_ch.hit, rsp_ch.stored, rsp_ch.full_res, rsp_ch.slot);
      end else begin
        want = pending_q.pop_front();
        if (rsp_ch.hit !== want.hit || rsp_ch.stored !== want.stored ||
            rsp_ch.full_res !== want.full_res || rsp_ch.slot !== want.slot) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: expected hit,stored,full %b%b%b slot %0d, got %b%b%b slot %0d",
                     $realtime, want.hit, want.stored, want.full_res, want.slot,
                     rsp_ch.hit, rsp_ch.stored, rsp_ch.full_res, rsp_ch.slot);
        end
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles with %0d results pending", cycle_cnt, pending_q.size());
    $display("FAILURE");
    $finish;
  end

  initial begin : main_seq
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.key      = '0;
    rsp_ch.ready    = 1'b0;
    rst_ni          = 1'b0;
    fail_cnt        = 0;
    send_idle       = 1'b1;
    recv_idle       = 1'b1;
    rsp_hold_len    = 0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tbl_keys[i]  = '0;
      tbl_valid[i] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_traffic();
    test_back_to_back();
    test_output_backpressure();
    test_drain_pause();

    // Let the last results out and watch for strays
    release_req();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      fail_cnt++;
      $display("%0d expected results never arrived", pending_q.size());
    end
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/hps_pkg.sv
hw/rtl/hps_if.sv
hw/rtl/hps_useq.sv
hw/rtl/hps_dpath.sv
hw/rtl/linear_probe_hash_set_unit.sv
tb/linear_probe_hash_set_unit_tb.sv
